// ----- hw/rtl/ncp_pkg.sv -----
package ncp_pkg;

  // fixed-point layout of the normalized value
  localparam int FRAC_W = 16;
  localparam int NORM_W = FRAC_W + 1;
  localparam int TERM_W = NORM_W + 1;
  localparam int POLY_W = 20;
  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd2;

  localparam logic [15:0] MIN_RESET     = 16'sd0;
  localparam logic [15:0] MAX_RESET     = 16'sd256;
  localparam logic [15:0] RANGE_DEFAULT = 16'd256;

  // color map codes
  localparam logic [1:0] MODE_GRAY    = 2'd0;
  localparam logic [1:0] MODE_HEAT    = 2'd1;
  localparam logic [1:0] MODE_VIRIDIS = 2'd2;

  // heatmap segment geometry
  localparam logic [14:0] SEG_WIDTH = 15'd16384;

  // viridis coefficients, round(c * 65536)
  localparam logic signed [POLY_W-1:0] VR0 = 20'sd17498;
  localparam logic [NORM_W-1:0] VR1 = 17'd21561;
  localparam logic [NORM_W-1:0] VR2 = 17'd82575;
  localparam logic [NORM_W-1:0] VR3 = 17'd121635;
  localparam logic signed [POLY_W-1:0] VG0 = 20'sd262;
  localparam logic [NORM_W-1:0] VG1 = 17'd66585;
  localparam logic [NORM_W-1:0] VG2 = 17'd20709;
  localparam logic signed [POLY_W-1:0] VB0 = 20'sd21561;
  localparam logic [NORM_W-1:0] VB1 = 17'd27787;
  localparam logic [NORM_W-1:0] VB2 = 17'd49349;
  localparam logic [NORM_W-1:0] VB3 = 17'd26280;

  typedef struct packed {
    logic              zero;
    logic              sat;
    logic [FRAC_W-1:0] rem;
    logic [FRAC_W-1:0] quo;
  } div_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one restoring division step, one quotient bit
  function automatic div_state_t div_step(input div_state_t s, input logic [FRAC_W-1:0] rng);
    logic [FRAC_W:0] shifted;
    logic [FRAC_W:0] diff;
    logic            ge;
    div_state_t      r;
    shifted = {s.rem, 1'b0};
    diff    = shifted - {1'b0, rng};
    ge      = (shifted >= {1'b0, rng});
    r       = s;
    r.rem   = ge ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
    r.quo   = {s.quo[FRAC_W-2:0], ge};
    return r;
  endfunction

  // unsigned q16 product, truncated
  function automatic logic [TERM_W-1:0] q16_mul(input logic [NORM_W-1:0] a,
                                                input logic [NORM_W-1:0] b);
    logic [2*NORM_W-1:0] prod;
    prod = a * b;
    return prod[2*NORM_W-1:FRAC_W];
  endfunction

  // positive q16 value scaled to 0..255 with saturation
  function automatic logic [7:0] to_byte(input logic signed [POLY_W-1:0] p);
    logic [POLY_W+7:0] scaled;
    logic [11:0]       v;
    scaled = {p, 8'b0} - {8'b0, p};
    v      = scaled[POLY_W+7:FRAC_W];
    if (p[POLY_W-1] || (p == '0)) begin
      return 8'd0;
    end
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

// ----- hw/rtl/normalize_and_colormap_pixel_core.sv -----
// normalize and colormap pixel core
// input channel: in_valid/in_ready carry one signed q8.8 sample per transfer.
// output channel: out_valid/out_ready carry one rgb pixel (out_red, out_green,
// out_blue) per transfer, in input order, one pixel per sample.
// configuration: cfg_we writes cfg_data into register cfg_index (0 min_value,
// 1 max_value, 2 color_mode); write only while no sample is in flight.
// throughput: one sample per clock, sustained, while the receiver keeps up.
// pipeline: the 16-stage radix-2 divider that forms (sample - min) / range is
// the deepest part; the viridis powers, coefficient terms and sums add four
// more stages.
// stall: a two-entry output (register plus skid) lets one more pixel land
// after out_ready drops; in_ready then falls and the whole pipeline holds.
// reset: synchronous, active low; all stage valid bits clear, registers go to
// min 0, max 1.0, grayscale, and in_ready is high in the first cycle after.
module normalize_and_colormap_pixel_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  input  logic                                cfg_we,
  input  logic [ncp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ncp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ncp_pkg::*;

  localparam int DW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;
  localparam int DIV_STAGES = FRAC_W;

  // configuration registers
  logic signed [15:0] min_value_r;
  logic signed [15:0] max_value_r;
  logic [1:0]         color_mode_r;
  logic [15:0]        range_r;
  logic [15:0]        range_nxt;
  logic signed [16:0] span;

  // pipeline registers
  logic                          en;
  logic                          a_v_r;
  logic signed [SAMPLE_WIDTH-1:0] a_sample_r;
  logic [DIV_STAGES:0]           st_v_r;
  div_state_t                    st_r [DIV_STAGES+1];
  div_state_t                    st0_nxt;

  logic                          p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [NORM_W-1:0]             p1_n_r, p1_n2_r, p2_n3_r;
  logic [TERM_W-1:0]             p1_tr1_r, p1_tg1_r, p1_tb1_r;
  logic [TERM_W-1:0]             p2_tr1_r, p2_tg1_r, p2_tb1_r;
  logic [TERM_W-1:0]             p2_tr2_r, p2_tg2_r, p2_tb2_r;
  logic [TERM_W-1:0]             p3_tr1_r, p3_tg1_r, p3_tb1_r;
  logic [TERM_W-1:0]             p3_tr2_r, p3_tg2_r, p3_tb2_r;
  logic [TERM_W-1:0]             p3_tr3_r, p3_tb3_r;
  logic signed [POLY_W-1:0]      p4_pr_r, p4_pg_r, p4_pb_r;
  rgb_t                          p1_simple_r, p2_simple_r, p3_simple_r, p4_simple_r;

  // output register and skid stage
  logic out_valid_r;
  logic skid_v_r;
  rgb_t out_rgb_r;
  rgb_t skid_rgb_r;
  rgb_t pix_nxt;

  // config writes and range
  always_comb begin
    span = $signed({max_value_r[15], max_value_r}) - $signed({min_value_r[15], min_value_r});
    if (!span[16] && (span != '0)) begin
      range_nxt = span[15:0];
    end else begin
      range_nxt = RANGE_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r  <= MIN_RESET;
      max_value_r  <= MAX_RESET;
      color_mode_r <= MODE_GRAY;
      range_r      <= RANGE_DEFAULT;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_VALUE:  min_value_r  <= cfg_data;
          REG_MAX_VALUE:  max_value_r  <= cfg_data;
          REG_COLOR_MODE: color_mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      range_r <= range_nxt;
    end
  end

  // the whole pipeline moves unless the skid stage holds a pixel
  assign en       = ~skid_v_r;
  assign in_ready = en;

  // difference, clamp flags and divider seed
  always_comb begin
    logic signed [DW-1:0] s_ext;
    logic signed [DW-1:0] m_ext;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] r_ext;
    s_ext = {{(DW-SAMPLE_WIDTH){a_sample_r[SAMPLE_WIDTH-1]}}, a_sample_r};
    m_ext = {{(DW-16){min_value_r[15]}}, min_value_r};
    r_ext = {{(DW-16){1'b0}}, range_r};
    d     = s_ext - m_ext;
    st0_nxt.zero = d[DW-1] | (d == '0);
    st0_nxt.sat  = ~st0_nxt.zero & (d >= r_ext);
    st0_nxt.rem  = (st0_nxt.zero | st0_nxt.sat) ? '0 : d[FRAC_W-1:0];
    st0_nxt.quo  = '0;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      st_v_r <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_valid;
      st_v_r <= {st_v_r[DIV_STAGES-1:0], a_v_r};
      p1_v_r <= st_v_r[DIV_STAGES];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  // input register and divider stages, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      a_sample_r <= in_sample;
      st_r[0]    <= st0_nxt;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        st_r[k] <= div_step(st_r[k-1], range_r);
      end
    end
  end

  // stage 1: normalized value, first powers, grayscale and heatmap
  logic [NORM_W-1:0] n_c;
  logic [TERM_W-1:0] n2_c;
  rgb_t              simple_c;

  always_comb begin
    logic [1:0]  seg;
    logic [14:0] off;
    logic [24:0] gw;
    logic [24:0] tw;
    logic [7:0]  gray;
    logic [7:0]  t;
    rgb_t        heat;
    if (st_r[DIV_STAGES].zero) begin
      n_c = '0;
    end else if (st_r[DIV_STAGES].sat) begin
      n_c = NORM_ONE;
    end else begin
      n_c = {1'b0, st_r[DIV_STAGES].quo};
    end
    n2_c = q16_mul(n_c, n_c);
    gw   = {n_c, 8'b0} - {8'b0, n_c};
    gray = gw[23:16];
    seg  = n_c[FRAC_W] ? 2'd3 : n_c[15:14];
    off  = n_c[FRAC_W] ? SEG_WIDTH : {1'b0, n_c[13:0]};
    tw   = {off, 10'b0} - {8'b0, off, 2'b0};
    t    = tw[23:16];
    case (seg)
      2'd0:    heat = '{red: 8'd0,   green: t,            blue: 8'd255};
      2'd1:    heat = '{red: 8'd0,   green: 8'd255,       blue: 8'd255 - t};
      2'd2:    heat = '{red: t,      green: 8'd255,       blue: 8'd0};
      default: heat = '{red: 8'd255, green: 8'd255 - t,   blue: 8'd0};
    endcase
    if (color_mode_r == MODE_HEAT) begin
      simple_c = heat;
    end else begin
      simple_c = '{red: gray, green: gray, blue: gray};
    end
  end

  // viridis pipeline: powers, coefficient terms and sums, at most one multiply deep per stage
  logic [TERM_W-1:0] n3_c;
  assign n3_c = q16_mul(p1_n2_r, p1_n_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n_r      <= n_c;
      p1_n2_r     <= n2_c[NORM_W-1:0];
      p1_tr1_r    <= q16_mul(VR1, n_c);
      p1_tg1_r    <= q16_mul(VG1, n_c);
      p1_tb1_r    <= q16_mul(VB1, n_c);
      p1_simple_r <= simple_c;

      p2_n3_r     <= n3_c[NORM_W-1:0];
      p2_tr2_r    <= q16_mul(VR2, p1_n2_r);
      p2_tg2_r    <= q16_mul(VG2, p1_n2_r);
      p2_tb2_r    <= q16_mul(VB2, p1_n2_r);
      p2_tr1_r    <= p1_tr1_r;
      p2_tg1_r    <= p1_tg1_r;
      p2_tb1_r    <= p1_tb1_r;
      p2_simple_r <= p1_simple_r;

      p3_tr3_r    <= q16_mul(VR3, p2_n3_r);
      p3_tb3_r    <= q16_mul(VB3, p2_n3_r);
      p3_tr1_r    <= p2_tr1_r;
      p3_tg1_r    <= p2_tg1_r;
      p3_tb1_r    <= p2_tb1_r;
      p3_tr2_r    <= p2_tr2_r;
      p3_tg2_r    <= p2_tg2_r;
      p3_tb2_r    <= p2_tb2_r;
      p3_simple_r <= p2_simple_r;

      p4_pr_r     <= VR0 + $signed({2'b0, p3_tr1_r}) + $signed({2'b0, p3_tr2_r})
                     - $signed({2'b0, p3_tr3_r});
      p4_pg_r     <= VG0 + $signed({2'b0, p3_tg1_r}) - $signed({2'b0, p3_tg2_r});
      p4_pb_r     <= VB0 + $signed({2'b0, p3_tb1_r}) - $signed({2'b0, p3_tb2_r})
                     + $signed({2'b0, p3_tb3_r});
      p4_simple_r <= p3_simple_r;
    end
  end

  // final pixel by color mode
  always_comb begin
    case (color_mode_r) inside
      MODE_GRAY, MODE_HEAT: pix_nxt = p4_simple_r;
      MODE_VIRIDIS: pix_nxt = '{red:   to_byte(p4_pr_r),
                                green: to_byte(p4_pg_r),
                                blue:  to_byte(p4_pb_r)};
      default: pix_nxt = '0;
    endcase
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= p4_v_r;
    end else begin
      skid_v_r <= p4_v_r;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_rgb_r <= skid_rgb_r;
      end
    end else if (!out_valid_r || out_ready) begin
      out_rgb_r <= pix_nxt;
    end else begin
      skid_rgb_r <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_rgb_r.red;
  assign out_green = out_rgb_r.green;
  assign out_blue  = out_rgb_r.blue;

endmodule

// ----- hw/rtl/ncp_checker.sv -----
module ncp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // stalled pixel stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped during a stall");

  // stalled pixel keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("output pixel changed during a stall");

  // input side only stalls while a pixel waits at the output
  a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending output pixel");

  // the skid entry drains in one transfer
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("in_ready stayed low after an output transfer");

  // reset empties the output side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output side not empty after reset");

endmodule

bind normalize_and_colormap_pixel_core ncp_checker u_ncp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

// ----- tb/tb_normalize_and_colormap_pixel_core.sv -----
`timescale 1ns / 1ps

module tb_normalize_and_colormap_pixel_core;
  import ncp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEMS_PER_BLK = 50;
  localparam int RANDOM_BLKS   = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int LATENCY_WAIT  = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 3000;

  // index with no register behind it, and the mode that maps to black
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  // viridis coefficients in q16
  localparam longint VIR_R0 = 17498;
  localparam longint VIR_R1 = 21561;
  localparam longint VIR_R2 = 82575;
  localparam longint VIR_R3 = 121635;
  localparam longint VIR_G0 = 262;
  localparam longint VIR_G1 = 66585;
  localparam longint VIR_G2 = 20709;
  localparam longint VIR_B0 = 21561;
  localparam longint VIR_B1 = 27787;
  localparam longint VIR_B2 = 49349;
  localparam longint VIR_B3 = 26280;
  localparam longint Q16_ONE = 65536;
  localparam longint HEAT_SEG = 16384;

  // expected pixel tracking
  class pixel_checker;
    logic signed [15:0] min_q;
    logic signed [15:0] max_q;
    logic [1:0]         mode;
    rgb_t               expected_pixels[$];
    int                 mismatches;

    function new();
      min_q = 16'sd0;
      max_q = 16'sd256;
      mode = MODE_GRAY;
      mismatches = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_MIN_VALUE:  min_q = data;
        REG_MAX_VALUE:  max_q = data;
        REG_COLOR_MODE: mode = data[1:0];
        default: ;
      endcase
    endfunction

    // positive q16 level to an 8-bit channel, saturating
    function logic [7:0] q16_to_channel(longint p);
      longint v;
      if (p <= 0) return 8'd0;
      v = (p * 255) >> 16;
      return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function rgb_t colormap(logic signed [15:0] sample);
      longint s, lo, hi, span, d, n, n2, n3, seg, t, pr, pg, pb;
      rgb_t   px;
      s = sample;
      lo = min_q;
      hi = max_q;
      span = (hi > lo) ? hi - lo : 256;
      d = s - lo;
      // normalize into 0..1 as q16, clamped at both ends
      if (d <= 0) n = 0;
      else if (d >= span) n = Q16_ONE;
      else n = (d << 16) / span;
      px = '0;
      case (mode)
        MODE_GRAY: begin
          px.red = 8'((n * 255) >> 16);
          px.green = px.red;
          px.blue = px.red;
        end
        MODE_HEAT: begin
          seg = n / HEAT_SEG;
          if (seg > 3) seg = 3;
          t = ((n - seg * HEAT_SEG) * 1020) >> 16;
          if (t > 255) t = 255;
          if (seg == 0) px = '{8'd0, 8'(t), 8'd255};
          else if (seg == 1) px = '{8'd0, 8'd255, 8'(255 - t)};
          else if (seg == 2) px = '{8'(t), 8'd255, 8'd0};
          else px = '{8'd255, 8'(255 - t), 8'd0};
        end
        MODE_VIRIDIS: begin
          n2 = (n * n) >> 16;
          n3 = (n2 * n) >> 16;
          pr = VIR_R0 + ((VIR_R1 * n) >> 16) + ((VIR_R2 * n2) >> 16) - ((VIR_R3 * n3) >> 16);
          pg = VIR_G0 + ((VIR_G1 * n) >> 16) - ((VIR_G2 * n2) >> 16);
          pb = VIR_B0 + ((VIR_B1 * n) >> 16) - ((VIR_B2 * n2) >> 16) + ((VIR_B3 * n3) >> 16);
          px.red = q16_to_channel(pr);
          px.green = q16_to_channel(pg);
          px.blue = q16_to_channel(pb);
        end
        default: px = '0;
      endcase
      return px;
    endfunction

    function void note_sample(logic signed [15:0] sample);
      expected_pixels.push_back(colormap(sample));
    endfunction

    function void compare_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_channel("red", want.red, got.red);
      compare_channel("green", want.green, got.green);
      compare_channel("blue", want.blue, got.blue);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [15:0]     in_sample;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_red;
  logic [7:0]             out_green;
  logic [7:0]             out_blue;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pixel_checker pix_check;
  int           tx_idle_pct;
  int           rx_stall_pct = 0;
  logic         rx_hold = 1'b0;
  int           hold_count = 0;
  int           stuck_cycles = 0;

  normalize_and_colormap_pixel_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver: check each pixel transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pix_check.check_pixel({out_red, out_green, out_blue});
    end
    if (rx_hold && hold_count < HOLD_CYCLES) begin
      hold_count++;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // offer one sample, with a random gap first, and hold it until transfer
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    pix_check.note_sample(value);
  endtask

  task automatic send_list(input logic signed [15:0] pts[$]);
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  // wait until every pixel is back and the pipeline is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pix_check.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    pix_check.note_config(idx, data);
  endtask

  // idle the block, then write all registers plus a stray index
  task automatic set_config(input logic signed [15:0] lo, input logic signed [15:0] hi,
                            input logic [1:0] mode);
    logic [15:0] mode_word;
    mode_word = 16'($urandom);
    mode_word[1:0] = mode;
    drain();
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_MIN_VALUE, lo);
    write_reg(REG_MAX_VALUE, hi);
    write_reg(REG_COLOR_MODE, mode_word);
    cfg_we <= 1'b0;
  endtask

  // sample mostly around the configured window, sometimes anywhere
  function automatic logic signed [15:0] pick_sample();
    int lo, hi, margin, a, b;
    if ($urandom_range(3) == 0) return 16'($urandom);
    lo = pix_check.min_q;
    hi = (pix_check.max_q > pix_check.min_q) ? int'(pix_check.max_q) : lo + 256;
    margin = (hi - lo) / 8 + 1;
    a = (lo - margin < -32768) ? -32768 : lo - margin;
    b = (hi + margin > 32767) ? 32767 : hi + margin;
    return 16'(a + int'($urandom_range(b - a)));
  endfunction

  initial begin
    logic signed [15:0] lo, hi;
    logic [1:0]         mode;
    int                 pick;
    pix_check = new();
    tx_idle_pct = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MIN_VALUE;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: grayscale over 0..1.0
    send_list('{-16'sd32768, 16'sd0, 16'sd1, 16'sd128, 16'sd255, 16'sd256, 16'sd32767});
    // heatmap around every segment boundary
    set_config(16'sd0, 16'sd256, MODE_HEAT);
    send_list('{16'sd63, 16'sd64, 16'sd127, 16'sd128, 16'sd191, 16'sd192, 16'sd256});
    // viridis at both ends and the middle
    set_config(16'sd0, 16'sd256, MODE_VIRIDIS);
    send_list('{16'sd0, 16'sd128, 16'sd256});
    // undefined mode gives black
    set_config(16'sd0, 16'sd256, MODE_UNDEF);
    send_sample(16'sd100);
    // widest possible range
    set_config(-16'sd32768, 16'sd32767, MODE_GRAY);
    send_list('{-16'sd32768, 16'sd32767});
    // inverted and empty ranges fall back to 1.0
    set_config(16'sd1000, -16'sd1000, MODE_GRAY);
    send_list('{16'sd1000, 16'sd1128});
    set_config(16'sd500, 16'sd500, MODE_HEAT);
    send_sample(16'sd756);

    // random blocks, each with its own settings and idling
    for (int blk = 0; blk < RANDOM_BLKS; blk++) begin
      pick = $urandom_range(9);
      mode = (pick == 9) ? MODE_UNDEF : 2'(pick % 3);
      if (blk == 0) begin
        lo = -16'sd32768;
        hi = 16'sd32767;
      end else if (blk == 1) begin
        lo = 16'sd32767;
        hi = -16'sd32768;
      end else begin
        case ($urandom_range(3))
          0: begin
            lo = 16'($urandom);
            hi = 16'($urandom);
          end
          1: begin
            lo = 16'($urandom);
            hi = (int'(lo) + 600 > 32767) ? 16'sd32767 : 16'(int'(lo) + $urandom_range(1, 600));
          end
          2: begin
            lo = 16'($urandom);
            hi = lo;
          end
          default: begin
            lo = 16'($urandom_range(4096)) - 16'sd2048;
            hi = lo + 16'($urandom_range(1, 8192));
          end
        endcase
      end
      set_config(lo, hi, mode);
      case (blk % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 78;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 78;
        end
        default: begin
          tx_idle_pct = 33;
          rx_stall_pct <= 33;
        end
      endcase
      // one block with a long receiver hold-off while samples keep coming
      rx_hold <= (blk == 4);
      for (int i = 0; i < ITEMS_PER_BLK; i++) send_sample(pick_sample());
    end

    // final drain and verdict
    in_valid <= 1'b0;
    while (pix_check.expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (pix_check.mismatches == 0 && pix_check.expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ncp_pkg.sv
hw/rtl/normalize_and_colormap_pixel_core.sv
hw/rtl/ncp_checker.sv
tb/tb_normalize_and_colormap_pixel_core.sv
